// File: hdl/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int POS_W = IDX_W + 1;

  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_EXACT = 3'd1,
    REQ_LOWER = 3'd2,
    REQ_CLAMP = 3'd3,
    REQ_UPPER = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [IDX_W-1:0]  entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             not_found;
  } out_item_t;

  typedef struct packed {
    logic write_entry;
    logic capture;
    logic probe;
    logic compare;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic range_empty;
    logic hit;
  } dp_status_t;

endpackage

// File: hdl/stbs_ctrl.sv
`timescale 1ns / 1ps

module stbs_ctrl import stbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] req_type_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.write_entry = 1'b1;
          end else if (req_type_i == REQ_EXACT || req_type_i == REQ_LOWER ||
                       req_type_i == REQ_CLAMP || req_type_i == REQ_UPPER) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        state_d     = status_i.range_empty ? ST_FINISH : ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd_o.compare = 1'b1;
        if (status_i.hit || status_i.range_empty) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/stbs_dp.sv
`timescale 1ns / 1ps

module stbs_dp import stbs_pkg::*; (
  input  logic             clk_i,
  input  in_item_t         in_data_i,
  input  logic [POS_W-1:0] table_length_i,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  output out_item_t        out_data_o
);

  entry_t mem [TABLE_DEPTH];

  entry_t           rdata_q;
  entry_t           key_q;
  req_e             req_q;
  logic [POS_W-1:0] len_q;
  logic [POS_W-1:0] low_q;
  logic [POS_W-1:0] hi_q;   // one past the inclusive upper end
  logic [IDX_W-1:0] mid_q;
  logic             hit_q;
  out_item_t        out_q;

  logic [POS_W-1:0] len_clamped;
  logic [POS_W-1:0] low_n;
  logic [POS_W-1:0] hi_n;
  logic [POS_W-1:0] span;
  logic [POS_W-1:0] mid_full;
  logic [IDX_W-1:0] mid_n;
  logic             eq;
  logic             issue;
  out_item_t        res;

  assign len_clamped = (table_length_i > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                               : table_length_i;

  always_comb begin
    low_n = low_q;
    hi_n  = hi_q;
    eq    = 1'b0;
    if (cmd_i.compare) begin
      if (rdata_q < key_q) begin
        low_n = {1'b0, mid_q} + POS_W'(1);
      end else if (rdata_q > key_q) begin
        hi_n = {1'b0, mid_q};
      end else begin
        eq = 1'b1;
      end
    end
  end

  // only meaningful while low_n < hi_n; otherwise the read is discarded
  assign span     = hi_n - low_n - POS_W'(1);
  assign mid_full = low_n + (span >> 1);
  assign mid_n    = mid_full[IDX_W-1:0];

  assign status_o.range_empty = (low_n >= hi_n);
  assign status_o.hit         = eq;

  assign issue = (cmd_i.probe || cmd_i.compare) && !eq;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      mem[in_data_i.entry_index] <= entry_t'(in_data_i.entry_value);
    end
    rdata_q <= mem[mid_n];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q <= entry_t'(in_data_i.search_key);
      req_q <= req_e'(in_data_i.req_type);
      len_q <= len_clamped;
      low_q <= '0;
      hi_q  <= len_clamped;
      hit_q <= 1'b0;
    end
    if (cmd_i.compare) begin
      low_q <= low_n;
      hi_q  <= hi_n;
      if (eq) begin
        hit_q <= 1'b1;
      end
    end
    if (issue) begin
      mid_q <= mid_n;
    end
    if (cmd_i.publish) begin
      out_q <= res;
    end
  end

  always_comb begin
    res = '0;
    unique case (req_q)
      REQ_EXACT: begin
        res.position  = hit_q ? {1'b0, mid_q} : '0;
        res.not_found = !hit_q;
      end
      REQ_LOWER, REQ_CLAMP: begin
        if (hit_q) begin
          res.position = {1'b0, mid_q};
        end else if (hi_q == '0) begin
          res.position = '0;            // key below the first entry, or empty table
        end else if (low_q >= len_q) begin
          if (req_q == REQ_LOWER) begin
            res.position  = len_q;
            res.not_found = 1'b1;
          end else begin
            res.position = len_q - POS_W'(1);
          end
        end else begin
          res.position = low_q;
        end
      end
      REQ_UPPER: begin
        res.position = hit_q ? ({1'b0, mid_q} + POS_W'(1)) : low_q;
      end
      default: res = '0;
    endcase
  end

  assign out_data_o = out_q;

endmodule

// File: hdl/sorted_table_binary_search.sv
`timescale 1ns / 1ps

// Sorted-table search engine. Load items write one signed entry into a
// 1024-word table and give no result; the entry must be written
// before any search reads it. Search items (exact, lower bound, clamped lower
// bound, upper bound) cover the first table_length entries, set over the APB
// port at address 0. Each is captured, probed, then halved until a hit or an
// empty range, at most 11 halvings for a full table: one table read per
// halving, with the compare and the next address in the same cycle. One item
// is in work at a time; a finished result waits in the output register while
// the next item is taken. Request codes 5 to 7 are taken and dropped.
module sorted_table_binary_search import stbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic [POS_W-1:0] table_length_q;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      table_length_q <= pwdata[POS_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-POS_W){1'b0}}, table_length_q} : '0;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_data_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  stbs_dp u_dp (
    .clk_i          (clk_i),
    .in_data_i      (in_data_i),
    .table_length_i (table_length_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_data_o     (out_data_o)
  );

endmodule
